// ===== rtl/core/scl_pkg.sv =====
// Shared types and constants for the small cache lookup and replace block.
// Payload structs for the request and response beats, opcodes and register indexes.
// No dependencies.
package scl_pkg;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 1;

  localparam logic [7:0] COUNT_MAX = 8'hFF;
  localparam logic [7:0] LFSR_SEED = 8'h01;

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_FILL   = 1'b1
  } scl_op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TWO_WAY = 1'b0,
    CFG_POLICY  = 1'b1
  } scl_cfg_e;

  typedef enum logic {
    POLICY_RANDOM = 1'b0,
    POLICY_LFU    = 1'b1
  } scl_policy_e;

  typedef struct packed {
    scl_op_e    opcode;
    logic [7:0] address;
    logic [5:0] tag;
    logic [1:0] set_index;
    logic [7:0] word;
  } scl_req_t;

  typedef struct packed {
    logic       hit;
    logic       evicted;
    logic [7:0] evicted_address;
  } scl_rsp_t;

  // State of the two ways of the set being filled.
  typedef struct packed {
    logic       valid0;
    logic       valid1;
    logic [7:0] count0;
    logic [7:0] count1;
  } scl_set_t;

  // Outcome of the victim choice for a fill.
  typedef struct packed {
    logic way;
    logic evict;
    logic replace;
  } scl_fill_t;

endpackage

// ===== rtl/core/scl_req_if.sv =====
// Request channel of the small cache: valid, ready and one request payload.
// Depends on scl_pkg.
interface scl_req_if
  import scl_pkg::*;
();

  logic     valid;
  logic     ready;
  scl_req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

// ===== rtl/core/scl_rsp_if.sv =====
// Response channel of the small cache: valid, ready and one response payload.
// Depends on scl_pkg.
interface scl_rsp_if
  import scl_pkg::*;
();

  logic     valid;
  logic     ready;
  scl_rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

// ===== rtl/core/scl_victim.sv =====
// Fill way selection for the small cache and the LFSR behind random replacement.
// Depends on scl_pkg.
module scl_victim
  import scl_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  logic      two_way_i,
  input  logic      lfu_i,
  input  scl_set_t  set_i,
  output scl_fill_t fill_o
);

  logic [7:0] lfsr_q;
  logic [7:0] lfsr_d;
  logic       lfsr_fb;

  always_comb begin
    fill_o = '0;
    priority if (!two_way_i) begin
      fill_o.way   = 1'b0;
      fill_o.evict = set_i.valid0;
    end else if (!set_i.valid0) begin
      fill_o.way = 1'b0;
    end else if (!set_i.valid1) begin
      fill_o.way = 1'b1;
    end else begin
      // set full: least used way, ties to way 0, or the LFSR's low bit
      fill_o.way     = lfu_i ? (set_i.count0 > set_i.count1) : lfsr_q[0];
      fill_o.evict   = 1'b1;
      fill_o.replace = 1'b1;
    end
  end

  // x^8+x^6+x^5+x^4+1, Fibonacci form
  assign lfsr_fb = lfsr_q[7] ^ lfsr_q[5] ^ lfsr_q[4] ^ lfsr_q[3];
  assign lfsr_d  = {lfsr_q[6:0], lfsr_fb};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfsr_q <= LFSR_SEED;
    end else if (step_i && fill_o.replace && !lfu_i) begin
      lfsr_q <= lfsr_d;
    end
  end

endmodule

// ===== rtl/core/small_cache_lookup_and_replace.sv =====
// Small cache with lookup and fill-with-replacement: NUM_SETS sets of NUM_WAYS lines,
// run direct mapped or two-way set associative. One request beat is taken per cycle
// unless a stalled response holds the pipeline, and each produces exactly one response
// beat. In the input register the line compare and victim choice are evaluated
// against the line state, and the result lands in the output register at the same
// edge as the state update; response valid rises once the beat moves on into the
// output register, and a stalled response only holds the pipeline once both registers
// are full. A lookup compares the full address against every valid line in use and,
// in LFU mode, bumps the use count (saturating at 255) of the first match in set order,
// way 0 first. A fill takes set_index modulo NUM_SETS and writes an empty way (way 0
// first) or evicts a victim chosen by an 8-bit LFSR or by the lower use count; in
// direct-mapped mode it always writes way 0. Configuration writes on the cfg_* port
// must only be issued while no beat is in flight; of the line state only the valid bits
// and use counts are reset, so requests are taken straight away.
module small_cache_lookup_and_replace
  import scl_pkg::*;
#(
  parameter int unsigned NUM_SETS  = 4,
  parameter int unsigned NUM_WAYS  = 2,
  parameter int unsigned ADDR_BITS = 8,
  parameter int unsigned DATA_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  scl_req_if.sink               req_i,
  scl_rsp_if.source             rsp_o
);

  localparam int unsigned NUM_LINES = NUM_SETS * NUM_WAYS;
  localparam int unsigned SET_W     = $clog2(NUM_SETS);
  localparam int unsigned LINE_W    = $clog2(NUM_LINES);
  localparam int unsigned RAW_W     = SET_W + 2;

  // Configuration registers
  logic        two_way_q;
  scl_policy_e policy_q;
  logic        two_way_eff;
  logic        lfu;

  // Input and output registers
  scl_req_t req_q;
  logic     req_vld_q;
  scl_rsp_t rsp_q;
  scl_rsp_t rsp_d;
  logic     rsp_vld_q;
  logic     advance;

  // Line state
  logic [NUM_LINES-1:0] valid_q;
  logic [7:0]           count_q [NUM_LINES];
  logic [5:0]           tag_q   [NUM_LINES];
  logic [DATA_BITS-1:0] data_q  [NUM_LINES];
  logic [ADDR_BITS-1:0] addr_q  [NUM_LINES];

  // Datapath
  logic [RAW_W-1:0]       set_raw;
  logic [RAW_W-1:0]       set_red;
  logic [SET_W-1:0]       set_sel;
  logic [LINE_W-1:0]      base_line;
  logic [LINE_W-1:0]      fill_line;
  logic [ADDR_BITS+7:0]   key_ext;
  logic [ADDR_BITS-1:0]   key;
  logic [DATA_BITS+7:0]   word_ext;
  logic [DATA_BITS-1:0]   word_st;
  logic [ADDR_BITS+7:0]   ev_ext;
  logic [NUM_LINES-1:0]   match;
  logic [NUM_LINES-1:0]   first_hit;
  logic                   any_hit;
  logic                   is_fill;
  scl_set_t               set_info;
  scl_fill_t              fill;

  assign two_way_eff = (NUM_WAYS > 1) && two_way_q;
  assign lfu         = (policy_q == POLICY_LFU);
  assign is_fill     = (req_q.opcode == OP_FILL);

  // Handshake: move a beat on when the output register is free or being drained
  assign advance     = req_vld_q && (!rsp_vld_q || rsp_o.ready);
  assign req_i.ready = !req_vld_q || advance;
  assign rsp_o.valid = rsp_vld_q;
  assign rsp_o.data  = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      two_way_q <= 1'b1;
      policy_q  <= POLICY_LFU;
    end else if (cfg_we_i) begin
      unique case (scl_cfg_e'(cfg_idx_i))
        CFG_TWO_WAY: two_way_q <= cfg_wdata_i[0];
        CFG_POLICY:  policy_q  <= scl_policy_e'(cfg_wdata_i[0]);
        default:     two_way_q <= two_way_q;
      endcase
    end
  end

  // Set select: set_index is below 4, so one conditional subtract reduces it
  assign set_raw   = RAW_W'(req_q.set_index);
  assign set_red   = (set_raw >= RAW_W'(NUM_SETS)) ? set_raw - RAW_W'(NUM_SETS) : set_raw;
  assign set_sel   = set_red[SET_W-1:0];
  assign base_line = LINE_W'(set_sel) << $clog2(NUM_WAYS);
  assign fill_line = base_line | LINE_W'(fill.way);

  // Fit the 8-bit address and word to the stored widths
  assign key_ext  = {{ADDR_BITS{1'b0}}, req_q.address};
  assign key      = key_ext[ADDR_BITS-1:0];
  assign word_ext = {{DATA_BITS{1'b0}}, req_q.word};
  assign word_st  = word_ext[DATA_BITS-1:0];
  assign ev_ext   = {8'd0, addr_q[fill_line]};

  // Parallel compare across all lines in use; way 1 only counts in two-way mode
  for (genvar l = 0; l < NUM_LINES; l++) begin : g_cmp
    assign match[l] = valid_q[l] && (addr_q[l] == key) &&
                      (((l % NUM_WAYS) == 0) || two_way_eff);
  end

  // Lowest set bit is the first match in set order, way 0 first
  assign first_hit = match & (~match + NUM_LINES'(1));
  assign any_hit   = |match;

  assign set_info.valid0 = valid_q[base_line];
  assign set_info.count0 = count_q[base_line];
  if (NUM_WAYS > 1) begin : g_way1
    assign set_info.valid1 = valid_q[base_line | LINE_W'(1)];
    assign set_info.count1 = count_q[base_line | LINE_W'(1)];
  end else begin : g_way1_none
    assign set_info.valid1 = 1'b0;
    assign set_info.count1 = 8'd0;
  end

  scl_victim u_victim (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance && is_fill),
    .two_way_i (two_way_eff),
    .lfu_i     (lfu),
    .set_i     (set_info),
    .fill_o    (fill)
  );

  always_comb begin
    rsp_d                 = '0;
    rsp_d.hit             = !is_fill && any_hit;
    rsp_d.evicted         = is_fill && fill.evict;
    rsp_d.evicted_address = rsp_d.evicted ? ev_ext[7:0] : 8'd0;
  end

  // Input register: take a beat whenever the stage is empty or moving on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
    end else if (req_i.valid && req_i.ready) begin
      req_vld_q <= 1'b1;
    end else if (advance) begin
      req_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      req_q <= req_i.data;
    end
  end

  // Output register: hold the result until the sink takes the beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_vld_q <= 1'b0;
    end else if (advance) begin
      rsp_vld_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      rsp_q <= rsp_d;
    end
  end

  // Valid bits and use counts; updated at the edge the beat leaves the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      for (int l = 0; l < NUM_LINES; l++) begin
        count_q[l] <= 8'd0;
      end
    end else if (advance) begin
      if (is_fill) begin
        valid_q[fill_line] <= 1'b1;
        if (fill.replace && lfu) begin
          count_q[fill_line] <= 8'd0;
        end
      end else if (lfu) begin
        for (int l = 0; l < NUM_LINES; l++) begin
          if (first_hit[l] && (count_q[l] != COUNT_MAX)) begin
            count_q[l] <= count_q[l] + 8'd1;
          end
        end
      end
    end
  end

  // Line payload; only ever read once the line's valid bit is set
  always_ff @(posedge clk_i) begin
    if (advance && is_fill) begin
      tag_q[fill_line]  <= req_q.tag;
      data_q[fill_line] <= word_st;
      addr_q[fill_line] <= key;
    end
  end

endmodule

// ===== tb/sv/tb_small_cache_lookup_and_replace.sv =====
// Self-checking testbench for small_cache_lookup_and_replace: a shadow of the cache state
// predicts each response beat, and random idling on both channels exercises the handshakes.
// Depends on scl_pkg, scl_req_if and scl_rsp_if.
import scl_pkg::*;

// Shadow copy of the cache lines, registers and victim LFSR; holds the responses still owed.
class cache_shadow;
  localparam int unsigned SETS = 4;

  logic        two_way = 1'b1;
  scl_policy_e policy  = POLICY_LFU;

  bit       line_valid   [SETS][2];
  bit [7:0] line_address [SETS][2];
  bit [7:0] use_count    [SETS][2];
  bit [7:0] victim_lfsr  = LFSR_SEED;

  scl_rsp_t    rsp_due[$];
  int unsigned failures;
  int unsigned hits;
  int unsigned evictions;
  int unsigned checked;
  bit          saturated;

  function void set_register(scl_cfg_e idx, logic v);
    case (idx)
      CFG_TWO_WAY: two_way = v;
      CFG_POLICY:  policy  = scl_policy_e'(v);
      default: ;
    endcase
  endfunction

  // Apply one accepted request beat to the shadow and queue the response it owes.
  function void predict_access(scl_req_t r);
    scl_rsp_t    e;
    int unsigned ways;
    int unsigned x;
    int unsigned y;
    int unsigned s;
    bit          way;
    e    = '0;
    ways = two_way ? 2 : 1;
    s    = r.set_index % SETS;
    if (r.opcode == OP_LOOKUP) begin
      for (x = 0; x < SETS && !e.hit; x++) begin
        for (y = 0; y < ways && !e.hit; y++) begin
          if (line_valid[x][y] && line_address[x][y] == r.address) begin
            e.hit = 1'b1;
            if (policy == POLICY_LFU && use_count[x][y] < COUNT_MAX) begin
              use_count[x][y]++;
              if (use_count[x][y] == COUNT_MAX) saturated = 1'b1;
            end
          end
        end
      end
      if (e.hit) hits++;
    end else begin
      if (!two_way) begin
        way = 1'b0;
        if (line_valid[s][0]) begin
          e.evicted         = 1'b1;
          e.evicted_address = line_address[s][0];
        end
      end else if (!line_valid[s][0]) begin
        way = 1'b0;
      end else if (!line_valid[s][1]) begin
        way = 1'b1;
      end else begin
        if (policy == POLICY_LFU) begin
          way = use_count[s][0] > use_count[s][1];
          use_count[s][way] = '0;
        end else begin
          way = victim_lfsr[0];
          victim_lfsr = {victim_lfsr[6:0],
                         victim_lfsr[7] ^ victim_lfsr[5] ^ victim_lfsr[4] ^ victim_lfsr[3]};
        end
        e.evicted         = 1'b1;
        e.evicted_address = line_address[s][way];
      end
      line_valid[s][way]   = 1'b1;
      line_address[s][way] = r.address;
      if (e.evicted) evictions++;
    end
    rsp_due.push_back(e);
  endfunction

  function void compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      failures++;
    end
  endfunction

  function void check_response(scl_rsp_t got);
    scl_rsp_t want;
    if (rsp_due.size() == 0) begin
      $display("%0t: unexpected response beat, expected none, actual %h", $time, got);
      failures++;
      return;
    end
    want = rsp_due.pop_front();
    compare_field("hit", want.hit, got.hit);
    compare_field("evicted", want.evicted, got.evicted);
    compare_field("evicted_address", want.evicted_address, got.evicted_address);
    checked++;
  endfunction

  function int unsigned outstanding();
    return rsp_due.size();
  endfunction

  function void report_leftovers();
    if (rsp_due.size() != 0) begin
      $display("%0t: %0d response beats never arrived, expected %h first, actual none",
               $time, rsp_due.size(), rsp_due[0]);
      failures += rsp_due.size();
    end
  endfunction
endclass

module tb_small_cache_lookup_and_replace;

  localparam int unsigned NUM_SETS  = 4;
  localparam int unsigned NUM_WAYS  = 2;
  localparam int unsigned ADDR_BITS = 8;
  localparam int unsigned DATA_BITS = 8;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  scl_req_if req ();
  scl_rsp_if rsp ();

  small_cache_lookup_and_replace #(
    .NUM_SETS  (NUM_SETS),
    .NUM_WAYS  (NUM_WAYS),
    .ADDR_BITS (ADDR_BITS),
    .DATA_BITS (DATA_BITS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req),
    .rsp_o       (rsp)
  );

  cache_shadow shadow = new;

  // Idling is switched off for the closing stretch; each side also has quiet spells.
  bit          idling_on = 1'b1;
  bit          sender_quiet;
  int unsigned beats_sent;
  logic [7:0]  addr_pool [16];

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Generous ceiling: far beyond the slowest legal run with every gap and stall at maximum.
  initial begin
    #1000000;
    $display("Some tests failed");
    $finish;
  end

  function automatic scl_req_t lookup_beat(input logic [7:0] a);
    scl_req_t r;
    r           = '0;
    r.opcode    = OP_LOOKUP;
    r.address   = a;
    // Fields a lookup ignores still toggle.
    r.tag       = 6'($urandom);
    r.set_index = 2'($urandom);
    r.word      = 8'($urandom);
    return r;
  endfunction

  function automatic scl_req_t fill_beat(input logic [7:0] a, input logic [5:0] t,
                                         input logic [1:0] s, input logic [7:0] w);
    scl_req_t r;
    r.opcode    = OP_FILL;
    r.address   = a;
    r.tag       = t;
    r.set_index = s;
    r.word      = w;
    return r;
  endfunction

  // Mostly addresses from a small pool so lookups hit and sets fill up; the rest span all 256.
  function automatic scl_req_t random_beat();
    logic [7:0] a;
    a = ($urandom_range(0, 3) == 0) ? 8'($urandom) : addr_pool[$urandom_range(0, 15)];
    if ($urandom_range(0, 1) == 1)
      return fill_beat(a, 6'($urandom), 2'($urandom), 8'($urandom));
    return lookup_beat(a);
  endfunction

  function automatic void refill_pool();
    foreach (addr_pool[i]) addr_pool[i] = 8'($urandom);
  endfunction

  // Drive one request beat, hold it until accepted, then hand it to the shadow.
  task automatic send_beat(input scl_req_t r);
    if (idling_on && !sender_quiet && $urandom_range(0, 7) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    req.valid <= 1'b1;
    req.data  <= r;
    do @(posedge clk_i); while (req.ready !== 1'b1);
    shadow.predict_access(r);
    beats_sent++;
    if (beats_sent % 64 == 0) sender_quiet = ($urandom_range(0, 2) == 0);
  endtask

  task automatic send_random(input int unsigned n);
    repeat (n) send_beat(random_beat());
  endtask

  // Drop valid and wait until every owed response has come back.
  task automatic drain();
    req.valid <= 1'b0;
    while (shadow.outstanding() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write both registers on consecutive edges; the pipeline must be empty first.
  task automatic reconfigure(input logic two_way, input scl_policy_e policy);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_TWO_WAY;
    cfg_wdata_i <= two_way;
    @(posedge clk_i);
    shadow.set_register(CFG_TWO_WAY, two_way);
    cfg_idx_i   <= CFG_POLICY;
    cfg_wdata_i <= policy;
    @(posedge clk_i);
    shadow.set_register(CFG_POLICY, policy);
    cfg_we_i    <= 1'b0;
    refill_pool();
  endtask

  // Fill one line, then hammer it with lookups so its use counter runs into saturation.
  task automatic saturate_line(input logic [7:0] a, input logic [1:0] s);
    send_beat(fill_beat(a, 6'($urandom), s, 8'($urandom)));
    repeat (260) send_beat(lookup_beat(a));
  endtask

  // Response side: check every accepted beat and stall ready in random bursts.
  initial begin : response_side
    int unsigned stall_left;
    bit          quiet;
    stall_left = 0;
    quiet      = 1'b0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
        shadow.check_response(rsp.data);
        if (shadow.checked % 50 == 0) quiet = ($urandom_range(0, 2) == 0);
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp.ready <= 1'b0;
      end else if (idling_on && !quiet && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 19) - 1;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int unsigned guard;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= CFG_TWO_WAY;
    cfg_wdata_i <= 1'b0;
    req.valid   <= 1'b0;
    req.data    <= '0;
    refill_pool();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, run at the reset settings: two-way with LFU victims.
    // Lookup on an empty cache: address 0 must miss, since no line is valid yet.
    send_beat(lookup_beat(8'h00));
    // Fill both ways of set 0 with the field extremes.
    send_beat(fill_beat(8'h00, 6'h00, 2'd0, 8'h00));
    send_beat(fill_beat(8'hFF, 6'h3F, 2'd0, 8'hFF));
    send_beat(lookup_beat(8'h00));
    send_beat(lookup_beat(8'hFF));
    send_beat(lookup_beat(8'hFF));
    // Set full, way 0 used less: way 0 goes, reporting evicted address 0.
    send_beat(fill_beat(8'h5A, 6'h15, 2'd0, 8'hA5));
    send_beat(lookup_beat(8'h00));
    // The new line starts at count 0, so way 0 goes again.
    send_beat(fill_beat(8'hA5, 6'h2A, 2'd0, 8'h55));
    repeat (3) send_beat(lookup_beat(8'hA5));
    // Way 0 now used more than way 1: way 1 is the victim.
    send_beat(fill_beat(8'h33, 6'h0C, 2'd0, 8'h3C));
    send_beat(lookup_beat(8'hFF));
    // The same address filled twice into one set; the lookup bumps way 0 only.
    send_beat(fill_beat(8'h81, 6'h15, 2'd3, 8'hAA));
    send_beat(fill_beat(8'h81, 6'h2A, 2'd3, 8'h55));
    send_beat(lookup_beat(8'h81));
    send_beat(fill_beat(8'h7E, 6'h01, 2'd1, 8'h80));
    send_beat(fill_beat(8'h42, 6'h3E, 2'd2, 8'h01));
    send_beat(lookup_beat(8'h42));
    send_beat(lookup_beat(8'h7E));
    send_beat(lookup_beat(8'hC3));

    // Random part, one phase per register setting; lines carry over across mode changes.
    reconfigure(1'b1, POLICY_RANDOM);
    send_random(200);
    reconfigure(1'b0, POLICY_LFU);
    send_random(140);
    reconfigure(1'b0, POLICY_RANDOM);
    send_random(140);
    reconfigure(1'b1, POLICY_LFU);
    saturate_line(8'h9C, 2'd2);
    addr_pool[0] = 8'h9C;
    send_random(100);

    // Closing stretch at full rate on both sides.
    idling_on = 1'b0;
    send_random(90);

    req.valid <= 1'b0;
    for (guard = 0; shadow.outstanding() != 0 && guard < 2000; guard++) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    shadow.report_leftovers();

    $display("Checked %0d response beats over direct-mapped and two-way, random and LFU phases",
             shadow.checked);
    $display("Lookup hits %0d, evictions %0d, use counter saturated: %0s",
             shadow.hits, shadow.evictions, shadow.saturated ? "yes" : "no");
    if (shadow.failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
